>>> sv/afb_pkg.sv
// package: types, widths and the sigmoid table for the activation unit
`timescale 1ns / 1ps

package afb_pkg;

  // fixed-point format and table size
  localparam int DATA_W      = 16;
  localparam int FRAC_BITS   = 12;
  localparam int LUT_ENTRIES = 256;
  localparam int LUT_BITS    = $clog2(LUT_ENTRIES);

  // sigmoid input window [-8,8) covers 2^SPAN_BITS codes
  localparam int SPAN_BITS = FRAC_BITS + 4;
  localparam int FRAC_SH   = SPAN_BITS - LUT_BITS;

  // forward argument, wide enough for 2x and for +/-8.0
  localparam int X_W = (DATA_W + 2 > FRAC_BITS + 6) ? DATA_W + 2 : FRAC_BITS + 6;

  // table entry: sample value and step to the next sample
  localparam int SIG_W   = FRAC_BITS + 1;
  localparam int DELTA_W = FRAC_BITS + 2;
  localparam int TBL_W   = SIG_W + DELTA_W;
  localparam int DG_W    = DELTA_W + FRAC_SH + 1;
  localparam int FWD_W   = SIG_W + 3;

  // gradient datapath widths
  localparam int OPB_W   = DATA_W + 1;
  localparam int PROD1_W = DATA_W + OPB_W;
  localparam int PROD2_W = PROD1_W + DATA_W;
  localparam int RND_SH  = 2 * FRAC_BITS;
  localparam int TERM_W  = PROD2_W - RND_SH;
  localparam int SUM_W   = TERM_W + 1;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 2;

  localparam logic signed [X_W-1:0] X_EIGHT = X_W'(8 * (1 << FRAC_BITS));

  typedef enum logic [1:0] {
    FN_RELU    = 2'd0,
    FN_SIGMOID = 2'd1,
    FN_TANH    = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    LAYOUT_REAL    = 2'd0,
    LAYOUT_COMPLEX = 2'd1,
    LAYOUT_MIXED   = 2'd2
  } layout_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FUNCTION  = 2'd0,
    REG_GRAD_MODE = 2'd1,
    REG_LAYOUT    = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] upstream_re;
    logic signed [DATA_W-1:0] upstream_im;
    logic signed [DATA_W-1:0] accum_re;
    logic signed [DATA_W-1:0] accum_im;
  } afb_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result_re;
    logic signed [DATA_W-1:0] result_im;
    logic                     saturated;
  } afb_out_t;

  // per-request control that travels down the pipeline
  typedef struct packed {
    func_e   func;
    logic    grad;
    layout_e layout;
  } afb_ctrl_t;

  typedef logic [LUT_ENTRIES-1:0][TBL_W-1:0] sig_tbl_t;

  // restoring division, used only while building the table
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      if (r >= den) begin
        r    = r - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // sigmoid at sample point k of the [-8,8] grid, rounded to nearest
  function automatic logic [63:0] sig_sample(input int k);
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] p;
    logic [63:0] w;
    logic [63:0] term;
    logic [63:0] e;
    logic [63:0] d;
    logic [63:0] s;
    logic [63:0] one;
    one  = 64'(1) << FRAC_BITS;
    a    = 64'(16) * 64'(k);
    b    = 64'(8) * 64'(LUT_ENTRIES);
    p    = (a < b) ? (b - a) : (a - b);
    w    = udiv64(p << 24, b);
    term = 64'(1) << 24;
    e    = term;
    // exp series in Q24
    for (int i = 1; i <= 12; i++) begin
      term = udiv64((term * w) >> 24, 64'(i));
      e    = e + term;
    end
    for (int i = 0; i < 3; i++) begin
      e = (e * e) >> 24;
    end
    d = (64'(1) << 24) + e;
    s = udiv64((one << 24) + (d >> 1), d);
    return (a < b) ? s : (one - s);
  endfunction

  // entry i holds {sample i, sample i+1 minus sample i}
  function automatic sig_tbl_t build_sig_tbl();
    sig_tbl_t    tbl;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] dl;
    for (int i = 0; i < LUT_ENTRIES; i++) begin
      lo     = sig_sample(i);
      hi     = sig_sample(i + 1);
      dl     = hi - lo;
      tbl[i] = {lo[SIG_W-1:0], dl[DELTA_W-1:0]};
    end
    return tbl;
  endfunction

  localparam sig_tbl_t SIG_TBL = build_sig_tbl();

endpackage

>>> sv/activation_forward_backward_unit.sv
// top level: pipelined relu / sigmoid / tanh activation and gradient accumulate
// a taken request moves through the stage 1, stage 2, stage 3 and output registers;
// the result strobe comes from the output register
// throughput: one request per cycle; busy_o stays low since the four-stage
// pipeline never stalls and the receiver takes every result
// reset: drops requests in flight, sets relu, forward mode and real layout
`timescale 1ns / 1ps

module activation_forward_backward_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  afb_pkg::afb_in_t               in_i,
  input  logic                           cfg_we_i,
  input  logic [afb_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [afb_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic                           result_valid_o,
  output afb_pkg::afb_out_t              result_o
);
  import afb_pkg::*;

  localparam logic signed [OPB_W-1:0]   OPB_ONE  = OPB_W'(1 << FRAC_BITS);
  localparam logic signed [PROD1_W-1:0] ONE_SQ   = PROD1_W'(1) << (2 * FRAC_BITS);
  localparam logic signed [PROD2_W-1:0] RND_HALF = PROD2_W'(1) << (RND_SH - 1);
  localparam logic signed [DG_W-1:0]    DG_HALF  = DG_W'(1) << (FRAC_SH - 1);
  localparam logic signed [FWD_W-1:0]   FWD_ONE  = FWD_W'(1 << FRAC_BITS);
  localparam logic signed [SUM_W-1:0]   SAT_MAX  = SUM_W'((1 << (DATA_W - 1)) - 1);
  localparam logic signed [SUM_W-1:0]   SAT_MIN  = -(SUM_W'(1) << (DATA_W - 1));

  // configuration registers
  func_e   func_q;
  logic    grad_mode_q;
  layout_e layout_q;

  logic request;

  // stage 1 registers
  logic                       s1_valid_q;
  afb_ctrl_t                  s1_ctrl_q;
  afb_in_t                    s1_in_q;
  logic                       s1_lo_q, s1_hi_q;
  logic [LUT_BITS-1:0]        s1_idx_q;
  logic [FRAC_SH-1:0]         s1_frac_q;
  logic signed [PROD1_W-1:0]  s1_prod_q;

  // stage 2 registers
  logic                       s2_valid_q;
  afb_ctrl_t                  s2_ctrl_q;
  afb_in_t                    s2_in_q;
  logic                       s2_lo_q, s2_hi_q;
  logic [SIG_W-1:0]           s2_base_q;
  logic signed [DELTA_W-1:0]  s2_delta_q;
  logic [FRAC_SH-1:0]         s2_frac_q;
  logic signed [PROD1_W-1:0]  s2_coef_q;

  // stage 3 registers
  logic                       s3_valid_q;
  afb_ctrl_t                  s3_ctrl_q;
  afb_in_t                    s3_in_q;
  logic                       s3_lo_q, s3_hi_q;
  logic [SIG_W-1:0]           s3_base_q;
  logic signed [DG_W-1:0]     s3_dg_q;
  logic signed [PROD2_W-1:0]  s3_pre_q, s3_pim_q;

  // output registers
  logic                       out_valid_q;
  afb_out_t                   out_q;

  // stage 1 combinational
  logic signed [X_W-1:0]      x_s1;
  logic signed [X_W-1:0]      u_s1;
  logic signed [OPB_W-1:0]    y_s1;
  logic signed [OPB_W-1:0]    opb_s1;
  logic signed [PROD1_W-1:0]  prod_d;

  // stage 2 combinational
  logic [TBL_W-1:0]           tbl_s2;
  logic signed [PROD1_W-1:0]  coef_d;

  // stage 4 combinational
  logic signed [DG_W-1:0]     rnd_s4;
  logic signed [FWD_W-1:0]    sig_s4;
  logic signed [FWD_W-1:0]    fwd_s4;
  logic signed [DATA_W-1:0]   relu_s4;
  logic signed [TERM_W-1:0]   term_re, term_im;
  logic signed [SUM_W-1:0]    sum_re, sum_im;
  logic signed [DATA_W-1:0]   sat_re, sat_im;
  logic                       ovf_re, ovf_im;
  afb_out_t                   out_d;

  assign request = start_i && !busy_o;
  assign busy_o  = 1'b0;

  // configuration write decode
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      func_q      <= FN_RELU;
      grad_mode_q <= 1'b0;
      layout_q    <= LAYOUT_REAL;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FUNCTION:  func_q      <= func_e'(cfg_data_i);
        REG_GRAD_MODE: grad_mode_q <= cfg_data_i[0];
        REG_LAYOUT:    layout_q    <= layout_e'(cfg_data_i);
        default: ;
      endcase
    end
  end

  // stage 1: table index and range check, first gradient product
  always_comb begin
    x_s1 = X_W'(in_i.value);
    if (func_q == FN_TANH) begin
      x_s1 = X_W'(in_i.value) <<< 1;
    end
    u_s1 = x_s1 + X_EIGHT;
    y_s1 = OPB_W'(in_i.value);
    if (func_q == FN_SIGMOID) begin
      opb_s1 = OPB_ONE - y_s1;
    end else begin
      opb_s1 = y_s1;
    end
    prod_d = PROD1_W'(y_s1) * PROD1_W'(opb_s1);
  end

  // stage 2: table read, derivative coefficient
  always_comb begin
    tbl_s2 = SIG_TBL[s1_idx_q];
    if (s1_ctrl_q.func == FN_SIGMOID) begin
      coef_d = s1_prod_q;
    end else begin
      coef_d = ONE_SQ - s1_prod_q;
    end
  end

  // stage 4: interpolate and scale, or relu; round or gate the gradient and accumulate
  always_comb begin
    rnd_s4 = (s3_dg_q + DG_HALF) >>> FRAC_SH;
    sig_s4 = FWD_W'($signed({1'b0, s3_base_q})) + FWD_W'(rnd_s4);
    if (s3_lo_q) begin
      sig_s4 = '0;
    end else if (s3_hi_q) begin
      sig_s4 = FWD_ONE;
    end
    relu_s4 = (s3_in_q.value > 0) ? s3_in_q.value : '0;
    case (s3_ctrl_q.func)
      FN_SIGMOID: fwd_s4 = sig_s4;
      FN_TANH:    fwd_s4 = (sig_s4 <<< 1) - FWD_ONE;
      default:    fwd_s4 = FWD_W'(relu_s4);
    endcase

    // gradient terms, relu passes upstream where value is positive
    case (s3_ctrl_q.func)
      FN_SIGMOID, FN_TANH: begin
        term_re = TERM_W'((s3_pre_q + RND_HALF) >>> RND_SH);
        term_im = TERM_W'((s3_pim_q + RND_HALF) >>> RND_SH);
      end
      default: begin
        term_re = (s3_in_q.value > 0) ? TERM_W'(s3_in_q.upstream_re) : '0;
        term_im = (s3_in_q.value > 0) ? TERM_W'(s3_in_q.upstream_im) : '0;
      end
    endcase
    sum_re = SUM_W'(s3_in_q.accum_re) + SUM_W'(term_re);
    sum_im = SUM_W'(s3_in_q.accum_im) + SUM_W'(term_im);

    // clamp to the 16-bit range
    ovf_re = (sum_re > SAT_MAX) || (sum_re < SAT_MIN);
    ovf_im = (sum_im > SAT_MAX) || (sum_im < SAT_MIN);
    sat_re = (sum_re > SAT_MAX) ? DATA_W'(SAT_MAX) :
             (sum_re < SAT_MIN) ? DATA_W'(SAT_MIN) : DATA_W'(sum_re);
    sat_im = (sum_im > SAT_MAX) ? DATA_W'(SAT_MAX) :
             (sum_im < SAT_MIN) ? DATA_W'(SAT_MIN) : DATA_W'(sum_im);

    // result select
    out_d.result_im = s3_in_q.accum_im;
    out_d.saturated = 1'b0;
    if (!s3_ctrl_q.grad) begin
      out_d.result_re = DATA_W'(fwd_s4);
    end else begin
      out_d.result_re = sat_re;
      out_d.saturated = ovf_re;
      if (s3_ctrl_q.layout == LAYOUT_COMPLEX) begin
        out_d.result_im = sat_im;
        out_d.saturated = ovf_re || ovf_im;
      end
    end
  end

  // valid bits down the pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= request;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      out_valid_q <= s3_valid_q;
    end
  end

  // payload registers, loaded only when the stage carries a request
  always_ff @(posedge clk_i) begin
    if (request) begin
      s1_ctrl_q <= '{func: func_q, grad: grad_mode_q, layout: layout_q};
      s1_in_q   <= in_i;
      s1_lo_q   <= x_s1 < -X_EIGHT;
      s1_hi_q   <= x_s1 >= X_EIGHT;
      s1_idx_q  <= u_s1[SPAN_BITS-1 -: LUT_BITS];
      s1_frac_q <= u_s1[FRAC_SH-1:0];
      s1_prod_q <= prod_d;
    end
    if (s1_valid_q) begin
      s2_ctrl_q  <= s1_ctrl_q;
      s2_in_q    <= s1_in_q;
      s2_lo_q    <= s1_lo_q;
      s2_hi_q    <= s1_hi_q;
      s2_base_q  <= tbl_s2[TBL_W-1 -: SIG_W];
      s2_delta_q <= $signed(tbl_s2[DELTA_W-1:0]);
      s2_frac_q  <= s1_frac_q;
      s2_coef_q  <= coef_d;
    end
    if (s2_valid_q) begin
      s3_ctrl_q <= s2_ctrl_q;
      s3_in_q   <= s2_in_q;
      s3_lo_q   <= s2_lo_q;
      s3_hi_q   <= s2_hi_q;
      s3_base_q <= s2_base_q;
      s3_dg_q   <= DG_W'(s2_delta_q) * DG_W'($signed({1'b0, s2_frac_q}));
      s3_pre_q  <= PROD2_W'(s2_coef_q) * PROD2_W'(s2_in_q.upstream_re);
      s3_pim_q  <= PROD2_W'(s2_coef_q) * PROD2_W'(s2_in_q.upstream_im);
    end
    if (s3_valid_q) begin
      out_q <= out_d;
    end
  end

  assign result_valid_o = out_valid_q;
  assign result_o       = out_q;

endmodule

>>> dv/activation_forward_backward_unit_checker.sv
// checker: predicts each activation or gradient result and compares it on the result strobe
`timescale 1ns / 1ps

module activation_forward_backward_unit_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic                           busy_i,
  input  afb_pkg::afb_in_t               req_i,
  input  logic                           cfg_we_i,
  input  logic [afb_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [afb_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           result_valid_i,
  input  afb_pkg::afb_out_t              result_i,
  output int                             mismatches_o,
  output int                             outstanding_o,
  output int                             checked_o
);
  import afb_pkg::*;

  // fixed-point constants of the predictor
  localparam longint ONE      = 64'sd1 << FRAC_BITS;
  localparam longint SPAN     = 16 * ONE;
  localparam int     RND_BITS = 2 * FRAC_BITS;
  localparam longint Q_MAX    = (64'sd1 << (DATA_W - 1)) - 1;
  localparam longint Q_MIN    = -(64'sd1 << (DATA_W - 1));

  // sigmoid samples on the [-8,8] grid, one more than the table entries
  longint   sig_points [LUT_ENTRIES + 1];

  // register copy
  logic [1:0] fn_sel;
  logic       grad_on;
  logic [1:0] layout_sel;

  afb_out_t expected_results [$];
  afb_out_t oldest;
  int       mismatches;
  int       checked;

  assign mismatches_o  = mismatches;
  assign outstanding_o = expected_results.size();
  assign checked_o     = checked;

  // sigmoid at grid point k: exp series in Q24, raised to the eighth power
  function automatic longint sample_sigmoid(int k);
    longint unsigned a;
    longint unsigned b;
    longint unsigned offset;
    longint unsigned w;
    longint unsigned term;
    longint unsigned ex;
    longint unsigned den;
    longint unsigned s;
    a      = 64'd16 * longint'(k);
    b      = 64'd8 * LUT_ENTRIES;
    offset = (a < b) ? (b - a) : (a - b);
    w      = (offset << 24) / b;
    term   = 64'd1 << 24;
    ex     = term;
    for (int i = 1; i <= 12; i++) begin
      term = ((term * w) >> 24) / longint'(i);
      ex   = ex + term;
    end
    for (int i = 0; i < 3; i++) begin
      ex = (ex * ex) >> 24;
    end
    den = (64'd1 << 24) + ex;
    s   = ((longint'(ONE) << 24) + (den >> 1)) / den;
    return (a < b) ? longint'(s) : ONE - longint'(s);
  endfunction

  initial begin
    for (int k = 0; k <= LUT_ENTRIES; k++) begin
      sig_points[k] = sample_sigmoid(k);
    end
  end

  // interpolated sigmoid, clamped to 0 below -8 and to 1.0 from +8 on
  function automatic longint sigmoid_of(longint x);
    longint pos;
    longint idx;
    longint frac;
    if (x < -8 * ONE) return 0;
    if (x >= 8 * ONE) return ONE;
    pos  = (x + 8 * ONE) * LUT_ENTRIES;
    idx  = pos / SPAN;
    frac = pos % SPAN;
    return (sig_points[idx] * (SPAN - frac) + sig_points[idx + 1] * frac + SPAN / 2) / SPAN;
  endfunction

  // local derivative times upstream, rounded to nearest with ties up
  function automatic longint local_grad(longint y, longint up);
    longint prod;
    if (fn_sel == FN_SIGMOID) begin
      prod = y * (ONE - y) * up;
    end else if (fn_sel == FN_TANH) begin
      prod = (ONE * ONE - y * y) * up;
    end else begin
      return (y > 0) ? up : 0;
    end
    return (prod + (64'sd1 << (RND_BITS - 1))) >>> RND_BITS;
  endfunction

  function automatic logic signed [DATA_W-1:0] clamp_q(longint s);
    if (s > Q_MAX) return DATA_W'(Q_MAX);
    if (s < Q_MIN) return DATA_W'(Q_MIN);
    return DATA_W'(s);
  endfunction

  // expected result of one request under the current registers
  function automatic afb_out_t activate(afb_in_t req);
    afb_out_t res;
    longint   x;
    longint   y;
    longint   sum_re;
    longint   sum_im;
    x             = longint'(req.value);
    res.result_im = req.accum_im;
    res.saturated = 1'b0;
    if (!grad_on) begin
      if (fn_sel == FN_SIGMOID) begin
        y = sigmoid_of(x);
      end else if (fn_sel == FN_TANH) begin
        y = 2 * sigmoid_of(2 * x) - ONE;
      end else begin
        y = (x > 0) ? x : 0;
      end
      res.result_re = DATA_W'(y);
    end else begin
      sum_re        = longint'(req.accum_re) + local_grad(x, longint'(req.upstream_re));
      res.result_re = clamp_q(sum_re);
      if (sum_re > Q_MAX || sum_re < Q_MIN) res.saturated = 1'b1;
      // only the full complex layout updates the imaginary lane
      if (layout_sel == LAYOUT_COMPLEX) begin
        sum_im        = longint'(req.accum_im) + local_grad(x, longint'(req.upstream_im));
        res.result_im = clamp_q(sum_im);
        if (sum_im > Q_MAX || sum_im < Q_MIN) res.saturated = 1'b1;
      end
    end
    return res;
  endfunction

  // watch the channels: check results, track registers, predict requests
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fn_sel     = FN_RELU;
      grad_on    = 1'b0;
      layout_sel = LAYOUT_REAL;
      mismatches = 0;
      checked    = 0;
      expected_results.delete();
    end else begin
      if (result_valid_i) begin
        if (expected_results.size() == 0) begin
          $error("result strobe with no request pending");
          mismatches++;
        end else begin
          oldest = expected_results.pop_front();
          checked++;
          if (result_i.result_re !== oldest.result_re) begin
            $error("result_re: expected %0d, got %0d", oldest.result_re, result_i.result_re);
            mismatches++;
          end
          if (result_i.result_im !== oldest.result_im) begin
            $error("result_im: expected %0d, got %0d", oldest.result_im, result_i.result_im);
            mismatches++;
          end
          if (result_i.saturated !== oldest.saturated) begin
            $error("saturated: expected %0b, got %0b", oldest.saturated, result_i.saturated);
            mismatches++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_FUNCTION:  fn_sel = cfg_data_i[1:0];
          REG_GRAD_MODE: grad_on = cfg_data_i[0];
          REG_LAYOUT:    layout_sel = cfg_data_i[1:0];
          default: ;
        endcase
      end
      if (start_i && !busy_i) begin
        expected_results.push_back(activate(req_i));
      end
    end
  end

endmodule

>>> dv/activation_forward_backward_unit_test.sv
// testbench top: stimulus, register phases and verdict for the activation unit
`timescale 1ns / 1ps

module activation_forward_backward_unit_test;
  import afb_pkg::*;

  localparam int HALF_PERIOD     = 6;
  localparam int QUIET_LIMIT     = 2000;
  localparam int ITEMS_PER_PHASE = 92;

  // codes the package leaves unnamed
  localparam logic [1:0] FN_UNUSED     = 2'd3;
  localparam logic [1:0] LAYOUT_UNUSED = 2'd3;
  localparam logic       MODE_FORWARD  = 1'b0;
  localparam logic       MODE_GRADIENT = 1'b1;

  logic                  clk_i      = 1'b0;
  logic                  rst_ni     = 1'b0;
  logic                  start_i    = 1'b0;
  afb_in_t               in_i       = '0;
  logic                  cfg_we_i   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i  = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  busy_o;
  logic                  result_valid_o;
  afb_out_t              result_o;

  int mismatches;
  int outstanding;
  int checked;
  int sent        = 0;
  int phases      = 0;
  int quiet_count = 0;
  bit bursty      = 1'b0;

  always #HALF_PERIOD clk_i = ~clk_i;

  activation_forward_backward_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .in_i           (in_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  activation_forward_backward_unit_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_i         (busy_o),
    .req_i          (in_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .result_valid_i (result_valid_o),
    .result_i       (result_o),
    .mismatches_o   (mismatches),
    .outstanding_o  (outstanding),
    .checked_o      (checked)
  );

  // watchdog on cycles where neither a request nor a result moves
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || result_valid_o) begin
      quiet_count <= 0;
    end else if (quiet_count == QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_count <= quiet_count + 1;
    end
  end

  // mostly full-range codes, with weight on the extremes and on small values
  function automatic logic [DATA_W-1:0] pick_q16();
    case ($urandom_range(0, 9))
      0:       return 16'h8000 + 16'($urandom_range(0, 3));
      1:       return 16'h7fff - 16'($urandom_range(0, 3));
      2, 3:    return 16'($urandom_range(0, 3 * 4096) - 4096);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic afb_in_t random_request();
    afb_in_t req;
    req.value       = pick_q16();
    req.upstream_re = pick_q16();
    req.upstream_im = pick_q16();
    req.accum_re    = pick_q16();
    req.accum_im    = pick_q16();
    return req;
  endfunction

  function automatic afb_in_t make_request(logic [15:0] v, logic [15:0] up_re,
                                           logic [15:0] up_im, logic [15:0] acc_re,
                                           logic [15:0] acc_im);
    afb_in_t req;
    req.value       = v;
    req.upstream_re = up_re;
    req.upstream_im = up_im;
    req.accum_re    = acc_re;
    req.accum_im    = acc_im;
    return req;
  endfunction

  task automatic write_reg(reg_idx_e idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // drain the pipeline, then load all three registers
  task automatic configure(logic [1:0] fn, logic mode, logic [1:0] layout);
    start_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
    write_reg(REG_FUNCTION, fn);
    // upper data bit of the mode register is ignored by the block
    write_reg(REG_GRAD_MODE, {1'($urandom_range(0, 1)), mode});
    write_reg(REG_LAYOUT, layout);
    phases++;
  endtask

  // one request, after a random gap unless this phase runs back to back
  task automatic send_request(afb_in_t req);
    int gap;
    gap = bursty ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    in_i    <= req;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    sent++;
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // forward relu: extremes and the zero boundary
    configure(FN_RELU, MODE_FORWARD, LAYOUT_REAL);
    send_request(make_request(16'h7fff, 16'h1234, 16'h8000, 16'h7fff, 16'h8000));
    send_request(make_request(16'h8000, 16'h0000, 16'h7fff, 16'h8000, 16'h7fff));
    send_request(make_request(16'h0000, 16'hffff, 16'h0001, 16'h0000, 16'hffff));
    send_request(make_request(16'h0001, 16'h0001, 16'hffff, 16'hffff, 16'h0001));

    // forward sigmoid across the whole table
    configure(FN_SIGMOID, MODE_FORWARD, LAYOUT_COMPLEX);
    send_request(make_request(16'h8000, 16'h0, 16'h0, 16'h0, 16'h5555));
    send_request(make_request(16'h7fff, 16'h0, 16'h0, 16'h0, 16'haaaa));
    send_request(make_request(16'h0000, 16'h0, 16'h0, 16'h0, 16'h0));
    send_request(make_request(16'hffff, 16'h0, 16'h0, 16'h0, 16'h0));
    send_request(make_request(16'h0fff, 16'h0, 16'h0, 16'h0, 16'h0));

    // forward tanh, doubled argument running past both ends of the table
    configure(FN_TANH, MODE_FORWARD, LAYOUT_MIXED);
    send_request(make_request(16'h8000, 16'h0, 16'h0, 16'h0, 16'h0));
    send_request(make_request(16'h7fff, 16'h0, 16'h0, 16'h0, 16'h0));
    send_request(make_request(16'h4000, 16'h0, 16'h0, 16'h0, 16'h0));
    send_request(make_request(16'hbfff, 16'h0, 16'h0, 16'h0, 16'h0));
    send_request(make_request(16'h0000, 16'h0, 16'h0, 16'h0, 16'h0));

    // relu gradient, complex lanes clamped high and low
    configure(FN_RELU, MODE_GRADIENT, LAYOUT_COMPLEX);
    send_request(make_request(16'h0001, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000));
    send_request(make_request(16'h0000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000));

    // sigmoid gradient, mixed layout leaves the imaginary lane alone
    configure(FN_SIGMOID, MODE_GRADIENT, LAYOUT_MIXED);
    send_request(make_request(16'h0800, 16'h7fff, 16'h7fff, 16'h7fff, 16'h1234));
    send_request(make_request(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000));

    // tanh gradient, extreme saved value and the zero-derivative point
    configure(FN_TANH, MODE_GRADIENT, LAYOUT_COMPLEX);
    send_request(make_request(16'h8000, 16'h7fff, 16'h8000, 16'h0000, 16'h0000));
    send_request(make_request(16'h1000, 16'h7fff, 16'h8000, 16'h0123, 16'hfedc));

    // unused function and layout codes
    configure(FN_UNUSED, MODE_GRADIENT, LAYOUT_UNUSED);
    send_request(make_request(16'h0005, 16'h7fff, 16'h7fff, 16'h7fff, 16'h4321));
    configure(FN_UNUSED, MODE_FORWARD, LAYOUT_UNUSED);
    send_request(make_request(16'hfffb, 16'h0, 16'h0, 16'h0, 16'h4321));

    // random requests under every function, mode and layout
    for (int mode = 0; mode < 2; mode++) begin
      for (int fn = 0; fn < 4; fn++) begin
        for (int layout = 0; layout < (mode ? 4 : 1); layout++) begin
          configure(2'(fn), 1'(mode), mode ? 2'(layout) : 2'($urandom_range(0, 3)));
          bursty = ($urandom_range(0, 3) == 0);
          repeat (ITEMS_PER_PHASE) send_request(random_request());
        end
      end
    end

    // wait out the pipeline
    start_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("ran %0d requests over %0d register settings in forward and gradient modes",
             sent, phases);
    $display("compared %0d results, %0d field mismatches", checked, mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
sv/afb_pkg.sv
sv/activation_forward_backward_unit.sv
dv/activation_forward_backward_unit_checker.sv
dv/activation_forward_backward_unit_test.sv
